>>> design/wpcs_pkg.sv
// shared types, constants and state encoding for the white pixel centroid steering block
package wpcs_pkg;

  localparam int ROW_W   = 13;
  localparam int COL_W   = 12;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 23;
  localparam int TERM_W  = 14;
  localparam int DEN_W   = SUM_W;
  localparam int FRAC_W  = 14;
  localparam int NUM_W   = SUM_W + FRAC_W;
  localparam int Q_W     = 15;
  localparam int STEP_W  = 4;
  localparam int SPEED_W = 9;
  localparam int STEER_W = 16;

  localparam int JQ_DEPTH = 2;
  localparam int JQ_PTR_W = 1;
  localparam int JQ_CNT_W = 2;

  localparam logic [7:0]         WHITE_LEVEL   = 8'd255;
  localparam logic [ROW_W-1:0]   ROW_RESET     = 13'd2400;
  localparam logic [ROW_W-1:0]   MIN_ROW       = 13'd2;
  localparam logic [ROW_W-1:0]   MAX_ROW_BYTES = 13'd4096;
  localparam logic [CNT_W-1:0]   COUNT_MAX     = 23'h7FFFFF;
  localparam logic [SPEED_W-1:0] SPEED_Q12     = 9'd410;
  localparam logic [Q_W-1:0]     STEER_LIMIT   = 15'd16384;
  localparam logic [STEP_W-1:0]  DIV_TOP_STEP  = 4'd14;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_end;
  } wpcs_in_t;

  typedef struct packed {
    logic                      target_found;
    logic [SPEED_W-1:0]        forward_speed;
    logic signed [STEER_W-1:0] steering;
  } wpcs_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] offset_sum;
    logic [CNT_W-1:0]        hit_count;
    logic [ROW_W-1:0]        row_bytes;
  } wpcs_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } wpcs_state_t;

endpackage

>>> design/wpcs_front.sv
// front end: row width register, column tracking and per-frame hit accumulation
module wpcs_front import wpcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [ROW_W-1:0]     cfg_wdata,
  input  logic                 in_push,
  input  wpcs_in_t             in_data,
  input  logic                 jq_full,
  output logic                 in_full,
  output logic                 jq_push,
  output wpcs_job_t            jq_wdata
);

  logic [ROW_W-1:0]        row_bytes_r;
  logic [COL_W-1:0]        column_r, column_nxt;
  logic signed [SUM_W-1:0] offset_sum_r, offset_sum_nxt;
  logic [CNT_W-1:0]        hit_count_r, hit_count_nxt;
  logic [ROW_W-1:0]        eff_row;
  logic [ROW_W-1:0]        col_inc;
  logic signed [TERM_W-1:0] term;
  logic                    hit;
  logic                    accept;

  always_comb begin
    if (row_bytes_r < MIN_ROW) begin
      eff_row = MIN_ROW;
    end else if (row_bytes_r > MAX_ROW_BYTES) begin
      eff_row = MAX_ROW_BYTES;
    end else begin
      eff_row = row_bytes_r;
    end
  end

  assign accept  = in_push && !jq_full;
  assign in_full = jq_full;
  assign hit     = (in_data.pixel_byte == WHITE_LEVEL) && (hit_count_r != COUNT_MAX);
  assign term    = $signed({1'b0, column_r, 1'b0}) - $signed({1'b0, eff_row});
  assign col_inc = {1'b0, column_r} + 13'd1;

  always_comb begin
    offset_sum_nxt = offset_sum_r;
    hit_count_nxt  = hit_count_r;
    if (hit) begin
      offset_sum_nxt = offset_sum_r + SUM_W'(term);
      hit_count_nxt  = hit_count_r + 23'd1;
    end
    if (col_inc >= eff_row) begin
      column_nxt = '0;
    end else begin
      column_nxt = col_inc[COL_W-1:0];
    end
  end

  assign jq_push             = accept && in_data.frame_end;
  assign jq_wdata.offset_sum = offset_sum_nxt;
  assign jq_wdata.hit_count  = hit_count_nxt;
  assign jq_wdata.row_bytes  = eff_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r  <= ROW_RESET;
      column_r     <= '0;
      offset_sum_r <= '0;
      hit_count_r  <= '0;
    end else begin
      if (cfg_we) begin
        row_bytes_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_data.frame_end) begin
          column_r     <= '0;
          offset_sum_r <= '0;
          hit_count_r  <= '0;
        end else begin
          column_r     <= column_nxt;
          offset_sum_r <= offset_sum_nxt;
          hit_count_r  <= hit_count_nxt;
        end
      end
    end
  end

endmodule

>>> design/wpcs_jobq.sv
// two-entry queue of finished frame totals between front and back
module wpcs_jobq import wpcs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic         pop,
  input  wpcs_job_t    wdata,
  output logic         full,
  output logic         empty,
  output wpcs_job_t    rdata
);

  wpcs_job_t             entry_r [JQ_DEPTH];
  logic [JQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JQ_CNT_W-1:0]   cnt_r;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == JQ_CNT_W'(JQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> design/wpcs_back.sv
// back end: per-frame steering division, saturation and result register
module wpcs_back import wpcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      jq_empty,
  input  wpcs_job_t jq_rdata,
  output logic      jq_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output wpcs_out_t out_data
);

  wpcs_state_t       state_r, state_nxt;
  logic              neg_r, found_r;
  logic [SUM_W-1:0]  mag_r;
  logic [CNT_W-1:0]  count_r;
  logic [ROW_W-1:0]  row_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  rem_r, dsh_r;
  logic [Q_W-1:0]    q_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  wpcs_out_t         out_r;

  logic              out_load;
  logic              ovf;
  logic              ge;
  logic [Q_W-1:0]    q_sat;
  logic [STEER_W-1:0] q_ext;

  assign ovf   = {1'b0, rem_r} >= {den_r, 15'b0};
  assign ge    = rem_r >= dsh_r;
  assign q_sat = (q_r > STEER_LIMIT) ? STEER_LIMIT : q_r;
  assign q_ext = {1'b0, q_sat};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!jq_empty) begin
          state_nxt = (jq_rdata.hit_count != '0) ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = ovf ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    jq_pop   = (state_r == ST_IDLE) && !jq_empty;
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_pop);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        neg_r   <= jq_rdata.offset_sum < 0;
        mag_r   <= (jq_rdata.offset_sum < 0) ? SUM_W'(-jq_rdata.offset_sum)
                                             : SUM_W'(jq_rdata.offset_sum);
        count_r <= jq_rdata.hit_count;
        row_r   <= jq_rdata.row_bytes;
        found_r <= jq_rdata.hit_count != '0;
        q_r     <= '0;
      end
      ST_MUL: begin
        den_r <= DEN_W'(count_r) * DEN_W'(row_r);
        rem_r <= {mag_r, 14'b0};
      end
      ST_CHK: begin
        if (ovf) begin
          q_r <= STEER_LIMIT;
        end
        dsh_r  <= {den_r, 14'b0};
        step_r <= DIV_TOP_STEP;
      end
      ST_DIV: begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r    <= {q_r[Q_W-2:0], ge};
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r - 4'd1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_r.target_found  <= found_r;
      out_r.forward_speed <= found_r ? SPEED_Q12 : '0;
      out_r.steering      <= !found_r ? '0 : (neg_r ? $signed(q_ext) : -$signed(q_ext));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/white_pixel_centroid_steering.sv
// top level of the white pixel centroid steering block
// Usage:
//   input channel: push one image byte per request on in_data with in_push while
//   in_full is low; set frame_end on the last byte of a frame. Bytes are taken
//   at one per cycle while in_full is low; in_full rises only when two finished
//   frames are still waiting for the divider.
//   result channel: one request per frame on out_data while out_empty is low,
//   taken by out_pop. A frame with hits goes through multiply, overflow check,
//   15 divide steps (skipped on overflow) and load; a frame with no hits goes
//   straight to the load. The back end handles one frame at a time, so frames
//   arriving faster than it finishes them can fill the frame queue.
//   configuration: cfg_we with cfg_wdata writes the row width in bytes;
//   values below 2 act as 2 and above 4096 as 4096.
//   reset: row width returns to 2400; column, sums, frame queue and result register clear.
//   a stalled receiver holds the result register, then the back end, then
//   the frame queue, and finally raises in_full.
module white_pixel_centroid_steering import wpcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [ROW_W-1:0] cfg_wdata,
  input  logic             in_push,
  input  wpcs_in_t         in_data,
  output logic             in_full,
  input  logic             out_pop,
  output logic             out_empty,
  output wpcs_out_t        out_data
);

  logic         jq_push, jq_full, jq_pop, jq_empty;
  wpcs_job_t    jq_wdata, jq_rdata;

  wpcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .jq_full   (jq_full),
    .in_full   (in_full),
    .jq_push   (jq_push),
    .jq_wdata  (jq_wdata)
  );

  wpcs_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (jq_push),
    .pop    (jq_pop),
    .wdata  (jq_wdata),
    .full   (jq_full),
    .empty  (jq_empty),
    .rdata  (jq_rdata)
  );

  wpcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .jq_empty  (jq_empty),
    .jq_rdata  (jq_rdata),
    .jq_pop    (jq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    jq_push |-> !jq_full)
    else $error("frame queue written while full");

  a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.target_found) |->
      (out_data.forward_speed == '0 && out_data.steering == '0))
    else $error("no-target result carries speed or steering");

  a_target_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.target_found) |-> out_data.forward_speed == SPEED_Q12)
    else $error("target result with wrong speed");

  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.steering <= 16'sd16384 && out_data.steering >= -16'sd16384))
    else $error("steering outside saturation range");

endmodule
